// File: hdl/stq_pkg.sv
package stq_pkg;

    // Number of cells in the timeout chain.
    localparam int QUEUE_DEPTH = 16;

    // Most expiry results that one tick may give.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // Input request codes.
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        RES_ACCEPTED = 2'd0,
        RES_REJECTED = 2'd1,
        RES_EXPIRED  = 2'd2
    } result_kind_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    // One pending timeout.
    typedef struct packed {
        logic [32:0] deadline;
        logic [31:0] start_time;
        logic [31:0] duration;
        logic [15:0] tag;
    } entry_t;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

// File: hdl/stq_cell.sv
module stq_cell
    import stq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  logic       prev_after,
    input  logic       prev_valid,
    input  entry_t     prev_entry,
    input  logic       next_valid,
    input  entry_t     next_entry,
    output logic       after,
    output logic       valid,
    output entry_t     entry
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;

    // The new entry goes behind this one when this one's deadline is equal to or earlier than the new one.
    assign after = valid_reg && (entry_reg.deadline <= new_entry.deadline);

    // Insert keeps, takes the new entry or shifts toward the tail; pop shifts to the head.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.insert && !after)
        begin
            if (prev_after)
            begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
            else
            begin
                valid_next = prev_valid;
                entry_next = prev_entry;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Entry payload.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// File: hdl/sorted_timeout_queue_core.sv
// Channel | Signals                                         | Direction
// --------+-------------------------------------------------+----------
// in      | in_valid, in_stall, kind, duration, tag         | request in
// out     | out_valid, out_stall, result_kind, tag_res,     | result out
//         | start_time_res, duration_res, last              |
//
// An add: all cells compare against the new deadline at once and the
// entry is inserted in the same edge that registers its result.
// A tick first advances the counter, then pops each due expiry from the head cell,
// or finds that nothing is due; out_stall holds the pop.
// A new request is taken only when the controller is idle and the output register is empty.
// Reset clears the counter, the cell occupancy flags and the controller; no clearing pass.
module sorted_timeout_queue_core
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [31:0] duration,
    input  logic [15:0] tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] tag_res,
    output logic [31:0] start_time_res,
    output logic [31:0] duration_res,
    output logic        last
);

    state_t           state_reg;
    state_t           state_next;
    logic [31:0]      now_reg;
    logic [31:0]      now_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_kind_t     res_kind_reg;
    result_kind_t     res_kind_next;
    entry_t           res_entry_reg;
    entry_t           res_entry_next;
    logic             res_last_reg;
    logic             res_last_next;

    cell_ctrl_t ctrl;
    entry_t     new_entry;
    logic       cell_after [QUEUE_DEPTH];
    logic       cell_valid [QUEUE_DEPTH];
    entry_t     cell_entry [QUEUE_DEPTH];

    logic in_take;
    logic out_free;
    logic full;
    logic head_due;
    logic second_due;

    // New entry stamped with the current time.
    assign new_entry.deadline   = {1'b0, now_reg} + {1'b0, duration};
    assign new_entry.start_time = now_reg;
    assign new_entry.duration   = duration;
    assign new_entry.tag        = tag;

    // Chain of cells, head at index zero.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   p_after;
        logic   p_valid;
        entry_t p_entry;
        logic   n_valid;
        entry_t n_entry;

        if (i == 0)
        begin : g_head
            assign p_after = 1'b1;
            assign p_valid = 1'b0;
            assign p_entry = new_entry;
        end
        else
        begin : g_body
            assign p_after = cell_after[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign n_valid = cell_valid[i+1];
            assign n_entry = cell_entry[i+1];
        end

        stq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_after (p_after),
            .prev_valid (p_valid),
            .prev_entry (p_entry),
            .next_valid (n_valid),
            .next_entry (n_entry),
            .after      (cell_after[i]),
            .valid      (cell_valid[i]),
            .entry      (cell_entry[i])
        );
    end

    assign full       = cell_valid[QUEUE_DEPTH-1];
    assign head_due   = cell_valid[0] && (cell_entry[0].deadline <= {1'b0, now_reg});
    assign second_due = cell_valid[1] && (cell_entry[1].deadline <= {1'b0, now_reg});

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_take  = in_valid && !in_stall;

    // Controller: takes requests, drives cell commands and loads the result register.
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_kind_next  = res_kind_reg;
        res_entry_next = res_entry_reg;
        res_last_next  = res_last_reg;
        ctrl.insert    = 1'b0;
        ctrl.pop       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (kind == KIND_ADD)
                    begin
                        out_valid_next = 1'b1;
                        res_entry_next = new_entry;
                        res_last_next  = 1'b1;
                        if (full)
                        begin
                            res_kind_next = RES_REJECTED;
                        end
                        else
                        begin
                            res_kind_next = RES_ACCEPTED;
                            ctrl.insert   = 1'b1;
                        end
                    end
                    else
                    begin
                        if (now_reg != 32'hFFFF_FFFF)
                        begin
                            now_next = now_reg + 32'd1;
                        end
                        cnt_next   = '0;
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (!head_due)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    res_kind_next  = RES_EXPIRED;
                    res_entry_next = cell_entry[0];
                    res_last_next  = !second_due || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                    ctrl.pop       = 1'b1;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (res_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_kind_reg  <= res_kind_next;
        res_entry_reg <= res_entry_next;
        res_last_reg  <= res_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = res_kind_reg;
    assign tag_res        = res_entry_reg.tag;
    assign start_time_res = res_entry_reg.start_time;
    assign duration_res   = res_entry_reg.duration;
    assign last           = res_last_reg;

endmodule
